/* src/tpcm_pkg.sv */
// tpcm_pkg: shared constants, palette codes, node tables and color type
// for the thermal pseudo-color map; depends on nothing
package tpcm_pkg;

  localparam int FB   = 12;            // fraction bits of the normalized value
  localparam int ONE  = 1 << FB;
  localparam int VW   = FB + 1;        // normalized value 0..ONE
  localparam int DW   = FB + 1;        // segment length
  localparam int PW   = 8 + VW;        // |channel delta| * offset
  localparam int NW   = PW + 1;        // product plus half segment
  localparam int QDIV = 8;             // quotient bits of the lerp divide
  localparam int LERP_LAT = QDIV + 4;  // lerp latency in cycles
  localparam int TOT_LAT  = FB + LERP_LAT + 2;

  typedef enum logic [2:0] {
    PAL_IRON    = 3'd0,
    PAL_RAINBOW = 3'd1,
    PAL_GRAY    = 3'd2,
    PAL_HOT     = 3'd3,
    PAL_COOL    = 3'd4
  } pal_t;

  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_PAL  = 2'd2;

  // [2] blue, [1] green, [0] red
  typedef logic [2:0][7:0] bgr_t;

  function automatic logic [VW-1:0] pos_q(input int p);
    return VW'((p * ONE + 50) / 100);
  endfunction

  localparam logic [VW-1:0] IRON_Q [8] = '{pos_q(0), pos_q(10), pos_q(25), pos_q(40),
                                           pos_q(55), pos_q(70), pos_q(85), pos_q(100)};
  localparam logic [VW-1:0] HOT_Q [8]  = '{pos_q(0), pos_q(35), pos_q(65), pos_q(100),
                                           pos_q(100), pos_q(100), pos_q(100), pos_q(100)};

  localparam bgr_t IRON_C [8] = '{
    {8'd0, 8'd0, 8'd0}, {8'd20, 8'd0, 8'd80}, {8'd50, 8'd0, 8'd180},
    {8'd140, 8'd0, 8'd160}, {8'd200, 8'd30, 8'd30}, {8'd230, 8'd130, 8'd0},
    {8'd255, 8'd220, 8'd50}, {8'd255, 8'd255, 8'd255}};
  localparam bgr_t HOT_C [8] = '{
    {8'd0, 8'd0, 8'd0}, {8'd0, 8'd0, 8'd200}, {8'd0, 8'd200, 8'd255},
    {8'd255, 8'd255, 8'd255}, {8'd255, 8'd255, 8'd255}, {8'd255, 8'd255, 8'd255},
    {8'd255, 8'd255, 8'd255}, {8'd255, 8'd255, 8'd255}};

endpackage

/* src/tpcm_norm.sv */
// tpcm_norm: normalizes a temperature against low/high into a 0..1 fraction
// with a restoring divider, one quotient bit per stage; uses tpcm_pkg
module tpcm_norm (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic signed [15:0]     temp,
  input  logic signed [15:0]     lo,
  input  logic signed [15:0]     hi,
  output logic                   v_valid,
  output logic [tpcm_pkg::VW-1:0] v
);
  import tpcm_pkg::*;

  logic signed [16:0] num, rng_raw, rng;
  logic               vld_r  [FB+1];
  logic               zero_r [FB+1];
  logic               full_r [FB+1];
  logic [15:0]        rem_r  [FB+1];
  logic [15:0]        rng_r  [FB+1];
  logic [FB-1:0]      q_r    [FB+1];

  always_comb begin
    num     = 17'(temp) - 17'(lo);
    rng_raw = 17'(hi) - 17'(lo);
    // empty or reversed range falls back to one degree
    rng     = (rng_raw < 17'sd1) ? 17'sd100 : rng_raw;
  end

  always_ff @(posedge clk) begin
    logic [16:0] t2;
    if (!rst_n) begin
      for (int s = 0; s <= FB; s++) vld_r[s] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int s = 0; s < FB; s++) vld_r[s+1] <= vld_r[s];
    end
    zero_r[0] <= (num <= 17'sd0);
    full_r[0] <= (num >= rng);
    rem_r[0]  <= num[15:0];
    rng_r[0]  <= rng[15:0];
    q_r[0]    <= '0;
    for (int s = 0; s < FB; s++) begin
      t2 = {rem_r[s], 1'b0};
      zero_r[s+1] <= zero_r[s];
      full_r[s+1] <= full_r[s];
      rng_r[s+1]  <= rng_r[s];
      if (t2 >= {1'b0, rng_r[s]}) begin
        rem_r[s+1] <= 16'(t2 - {1'b0, rng_r[s]});
        q_r[s+1]   <= {q_r[s][FB-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= t2[15:0];
        q_r[s+1]   <= {q_r[s][FB-2:0], 1'b0};
      end
    end
  end

  assign v_valid = vld_r[FB];
  assign v = zero_r[FB] ? '0 : (full_r[FB] ? VW'(ONE) : {1'b0, q_r[FB]});

endmodule

/* src/tpcm_lerp.sv */
// tpcm_lerp: piecewise linear interpolation over the ironbow or hot node
// table with rounded division by the segment length; uses tpcm_pkg
module tpcm_lerp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    v_valid,
  input  logic [tpcm_pkg::VW-1:0] v,
  input  logic                    hot,
  output logic                    c_valid,
  output tpcm_pkg::bgr_t          color
);
  import tpcm_pkg::*;

  // segment select
  logic [VW-1:0]    q_sel [8];
  bgr_t             c_sel [8];
  logic [2:0]       seg, seg_last, seg_nx;
  logic [VW-1:0]    dv_a;

  logic                    a_vld_r, b_vld_r, o_vld_r;
  logic [VW-1:0]           a_dv_r;
  logic [DW-1:0]           a_den_r, b_den_r;
  bgr_t                    a_c0_r, b_c0_r;
  logic signed [2:0][8:0]  a_d_r;
  logic [2:0][PW-1:0]      b_mag_r;
  logic [2:0]              b_neg_r;

  logic                    d_vld_r [QDIV+1];
  logic [2:0][NW-1:0]      d_rem_r [QDIV+1];
  logic [2:0][QDIV-1:0]    d_q_r   [QDIV+1];
  logic [2:0]              d_neg_r [QDIV+1];
  logic [DW-1:0]           d_den_r [QDIV+1];
  bgr_t                    d_c0_r  [QDIV+1];
  bgr_t                    color_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      q_sel[i] = hot ? HOT_Q[i] : IRON_Q[i];
      c_sel[i] = hot ? HOT_C[i] : IRON_C[i];
    end
    seg_last = hot ? 3'd2 : 3'd6;
    seg = seg_last;
    // first segment whose upper node is at or above v
    for (int i = 6; i >= 0; i--) begin
      if (3'(i) <= seg_last && v <= q_sel[i+1]) seg = 3'(i);
    end
    seg_nx = 3'(seg + 3'd1);
    dv_a = (v > q_sel[seg]) ? VW'(v - q_sel[seg]) : '0;
  end

  always_ff @(posedge clk) begin
    logic [8:0] ad;
    logic [NW-1:0] sh;
    logic signed [9:0] r;
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
      for (int s = 0; s <= QDIV; s++) d_vld_r[s] <= 1'b0;
    end else begin
      a_vld_r <= v_valid;
      b_vld_r <= a_vld_r;
      d_vld_r[0] <= b_vld_r;
      for (int s = 0; s < QDIV; s++) d_vld_r[s+1] <= d_vld_r[s];
      o_vld_r <= d_vld_r[QDIV];
    end
    // stage a: segment, offset, length and channel deltas
    a_dv_r  <= dv_a;
    a_den_r <= DW'(q_sel[seg_nx] - q_sel[seg]);
    a_c0_r  <= c_sel[seg];
    for (int ch = 0; ch < 3; ch++) begin
      a_d_r[ch] <= $signed({1'b0, c_sel[seg_nx][ch]}) - $signed({1'b0, c_sel[seg][ch]});
    end
    // stage b: magnitude products
    b_den_r <= a_den_r;
    b_c0_r  <= a_c0_r;
    for (int ch = 0; ch < 3; ch++) begin
      ad = a_d_r[ch][8] ? 9'(-a_d_r[ch]) : 9'(a_d_r[ch]);
      b_mag_r[ch] <= PW'(ad[7:0]) * PW'(a_dv_r);
      b_neg_r[ch] <= a_d_r[ch][8];
    end
    // divide entry: add half the length for rounding
    d_den_r[0] <= b_den_r;
    d_c0_r[0]  <= b_c0_r;
    d_neg_r[0] <= b_neg_r;
    for (int ch = 0; ch < 3; ch++) begin
      d_rem_r[0][ch] <= NW'(b_mag_r[ch]) + NW'(b_den_r >> 1);
      d_q_r[0][ch]   <= '0;
    end
    // quotient stays below 256, so test length << k from the top bit down
    for (int s = 0; s < QDIV; s++) begin
      sh = NW'(d_den_r[s]) << (QDIV - 1 - s);
      d_den_r[s+1] <= d_den_r[s];
      d_c0_r[s+1]  <= d_c0_r[s];
      d_neg_r[s+1] <= d_neg_r[s];
      for (int ch = 0; ch < 3; ch++) begin
        if (d_rem_r[s][ch] >= sh) begin
          d_rem_r[s+1][ch] <= d_rem_r[s][ch] - sh;
          d_q_r[s+1][ch]   <= {d_q_r[s][ch][QDIV-2:0], 1'b1};
        end else begin
          d_rem_r[s+1][ch] <= d_rem_r[s][ch];
          d_q_r[s+1][ch]   <= {d_q_r[s][ch][QDIV-2:0], 1'b0};
        end
      end
    end
    // apply sign, add base color, clamp
    for (int ch = 0; ch < 3; ch++) begin
      if (d_neg_r[QDIV][ch])
        r = $signed({2'b00, d_c0_r[QDIV][ch]}) - $signed({2'b00, d_q_r[QDIV][ch]});
      else
        r = $signed({2'b00, d_c0_r[QDIV][ch]}) + $signed({2'b00, d_q_r[QDIV][ch]});
      if (r < 10'sd0)        color_r[ch] <= 8'd0;
      else if (r > 10'sd255) color_r[ch] <= 8'd255;
      else                   color_r[ch] <= r[7:0];
    end
  end

  assign c_valid = o_vld_r;
  assign color   = color_r;

endmodule

/* src/thermal_pseudo_color_map.sv */
// thermal_pseudo_color_map: top level, config registers, ramp palettes and
// output mux; uses tpcm_pkg, tpcm_norm and tpcm_lerp
//
// usage:
//   input: drive in_temperature_centi with start high; a word is taken at
//   every clock edge where start is high and busy is low. busy is high only
//   during reset, so one pixel per clock is taken with no gaps.
//   output: out_strobe is high for one cycle with out_blue/green/red; the
//   word must be taken then, there is no back-pressure.
//   pipeline: a result passes the bit-per-stage normalize divider (FB + 1
//   stages), the 12 stage table interpolation with its 8 stage rounding
//   divide, and the output register.
//   throughput: one pixel per cycle, fully pipelined.
//   config: cfg_we writes low/high/palette at cfg_index; write only while
//   the pipeline holds no words.
//   reset: rst_n low clears all valid bits and sets low 0, high 4000,
//   palette ironbow; words in flight are dropped.
module thermal_pseudo_color_map (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_temperature_centi,
  output logic               out_strobe,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_green,
  output logic [7:0]         out_red,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import tpcm_pkg::*;

  logic signed [15:0] low_r, high_r;
  pal_t               pal_r;

  logic               v_valid, c_valid;
  logic [VW-1:0]      v, w;
  logic [VW+1:0]      w4;
  logic [2:0]         sector;
  logic [7:0]         rise, fall, lin, cool_b;
  bgr_t               ramp, table_c;
  logic               table_pal;

  bgr_t               dly_r [LERP_LAT];
  bgr_t               out_r;
  logic               out_vld_r;

  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= 16'sd0;
      high_r <= 16'sd4000;
      pal_r  <= PAL_IRON;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW:  low_r  <= cfg_wdata;
        REG_HIGH: high_r <= cfg_wdata;
        REG_PAL:  pal_r  <= pal_t'(cfg_wdata[2:0]);
        default: ;
      endcase
    end
  end

  tpcm_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .temp     (in_temperature_centi),
    .lo       (low_r),
    .hi       (high_r),
    .v_valid  (v_valid),
    .v        (v)
  );

  tpcm_lerp u_lerp (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_valid (v_valid),
    .v       (v),
    .hot     (pal_r == PAL_HOT),
    .c_valid (c_valid),
    .color   (table_c)
  );

  // ramp palettes: rainbow hue sector from 4*(1-v), rise from the sector fraction; gray and cool from v
  always_comb begin
    w      = VW'(ONE) - v;
    w4     = {w, 2'b00};
    sector = w4[VW+1:FB];
    rise   = 8'((32'(w4[FB-1:0]) * 255 + ONE / 2) >> FB);
    fall   = 8'd255 - rise;
    lin    = 8'((32'(v) * 255) >> FB);
    cool_b = 8'((32'(w) * 255) >> FB);
    ramp   = '0;
    unique case (pal_r)
      PAL_RAINBOW: begin
        unique case (sector)
          3'd0:    ramp = {8'd0, rise, 8'd255};
          3'd1:    ramp = {8'd0, 8'd255, fall};
          3'd2:    ramp = {rise, 8'd255, 8'd0};
          3'd3:    ramp = {8'd255, fall, 8'd0};
          default: ramp = {8'd255, 8'd0, rise};
        endcase
      end
      PAL_GRAY: ramp = {lin, lin, lin};
      PAL_COOL: ramp = {cool_b, lin, 8'd0};
      default:  ramp = '0;
    endcase
    table_pal = !(pal_r == PAL_RAINBOW || pal_r == PAL_GRAY || pal_r == PAL_COOL);
  end

  // ramp colors wait alongside the interpolation pipeline
  always_ff @(posedge clk) begin
    dly_r[0] <= ramp;
    for (int s = 1; s < LERP_LAT; s++) dly_r[s] <= dly_r[s-1];
    out_r <= table_pal ? table_c : dly_r[LERP_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= c_valid;
  end

  assign out_strobe = out_vld_r;
  assign out_blue   = out_r[2];
  assign out_green  = out_r[1];
  assign out_red    = out_r[0];

endmodule

/* src/tpcm_checker.sv */
// tpcm_checker: port-level assertions for the thermal pseudo-color map and
// the bind that attaches them; uses tpcm_pkg
module tpcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_green,
  input logic [7:0]  out_red,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_wdata
);
  import tpcm_pkg::*;

  pal_t pal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pal_r <= PAL_IRON;
    else if (cfg_we && cfg_index == REG_PAL) pal_r <= pal_t'(cfg_wdata[2:0]);
  end

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TOT_LAT out_strobe)
    else $error("accepted word gave no strobe");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, TOT_LAT))
    else $error("strobe without an accepted word");

  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && pal_r == PAL_GRAY) |-> (out_blue == out_green && out_green == out_red))
    else $error("grayscale channels differ");

  a_cool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && pal_r == PAL_COOL) |-> (out_red == 8'd0))
    else $error("cool palette red not zero");

endmodule

bind thermal_pseudo_color_map tpcm_checker u_tpcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_blue   (out_blue),
  .out_green  (out_green),
  .out_red    (out_red),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index),
  .cfg_wdata  (cfg_wdata)
);
